FILE: sv/pbm_pkg.sv
// pbm_pkg: shared types, register codes and the divide-by-255 helper
// for the pixel blend mode unit. No dependencies.
package pbm_pkg;

  localparam int unsigned NUM_CH = 3;

  localparam logic [2:0] MODE_PASS     = 3'd0;
  localparam logic [2:0] MODE_SCREEN   = 3'd1;
  localparam logic [2:0] MODE_MULTIPLY = 3'd2;
  localparam logic [2:0] MODE_OVERLAY  = 3'd3;
  localparam logic [2:0] MODE_TRANS    = 3'd4;
  localparam logic [2:0] MODE_CONST    = 3'd5;
  localparam logic [2:0] MODE_HUE      = 3'd6;

  localparam logic [1:0] FMT_GRAY = 2'd0;
  localparam logic [1:0] FMT_RGB  = 2'd1;
  localparam logic [1:0] FMT_RGBA = 2'd2;

  localparam logic [1:0] CFG_BLEND_MODE   = 2'd0;
  localparam logic [1:0] CFG_BLEND_FORMAT = 2'd1;
  localparam logic [1:0] CFG_CONST_ALPHA  = 2'd2;

  localparam logic [7:0] FULL_ALPHA = 8'd255;

  typedef enum logic [2:0] {
    OP_SRC    = 3'd0,
    OP_BLEND  = 3'd1,
    OP_SCREEN = 3'd2,
    OP_MUL    = 3'd3,
    OP_OVL_LO = 3'd4,
    OP_OVL_HI = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] format;
    logic [7:0] const_alpha;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  s;
    logic [7:0]  b;
    logic [15:0] prod;
  } prod_ch_t;

  typedef struct packed {
    prod_ch_t [NUM_CH-1:0] ch;
    logic [7:0]            alpha;
  } prod_word_t;

  typedef struct packed {
    logic [7:0] s;
    logic [7:0] v;
  } val_ch_t;

  typedef struct packed {
    val_ch_t [NUM_CH-1:0] ch;
    logic [7:0]           alpha;
  } val_word_t;

  // floor(x/255), exact for x up to 65025
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

FILE: sv/pbm_prod.sv
// pbm_prod: first pipeline stage; decodes mode and layout per channel and
// forms the 8x8 product. Depends on pbm_pkg.
module pbm_prod
  import pbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] src_c0,
  input  logic [7:0] src_c1,
  input  logic [7:0] src_c2,
  input  logic [7:0] blend_c0,
  input  logic [7:0] blend_c1,
  input  logic [7:0] blend_c2,
  input  logic [7:0] blend_alpha,
  output logic       valid_o,
  input  logic       ready_i,
  output prod_word_t word_o
);

  logic       valid_r;
  prod_word_t word_r;
  prod_word_t word_nxt;
  logic [7:0] src_v [NUM_CH];
  logic [7:0] bl_v  [NUM_CH];
  logic       has_alpha;

  assign has_alpha = (cfg.format == FMT_RGBA);

  always_comb begin
    src_v[0] = src_c0;
    src_v[1] = src_c1;
    src_v[2] = src_c2;
    bl_v[0]  = blend_c0;
    if (cfg.format == FMT_GRAY) begin
      bl_v[1] = blend_c0;
      bl_v[2] = blend_c0;
    end else begin
      bl_v[1] = blend_c1;
      bl_v[2] = blend_c2;
    end
  end

  always_comb begin
    word_nxt.alpha = FULL_ALPHA;
    case (cfg.mode) inside
      MODE_SCREEN, MODE_MULTIPLY, MODE_OVERLAY, MODE_TRANS: begin
        word_nxt.alpha = has_alpha ? blend_alpha : FULL_ALPHA;
      end
      MODE_CONST: word_nxt.alpha = cfg.const_alpha;
      default:    word_nxt.alpha = FULL_ALPHA;
    endcase
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
    op_t         op;
    logic [7:0]  ma;
    logic [7:0]  mb;
    logic [15:0] m16;

    always_comb begin
      unique case (cfg.mode)
        MODE_SCREEN:   op = OP_SCREEN;
        MODE_MULTIPLY: op = OP_MUL;
        MODE_OVERLAY:  op = src_v[k][7] ? OP_OVL_HI : OP_OVL_LO;
        MODE_TRANS:    op = OP_BLEND;
        MODE_CONST:    op = OP_BLEND;
        MODE_HUE:      op = (k == 0) ? OP_BLEND : OP_SRC;
        default:       op = OP_SRC;
      endcase
    end

    assign ma  = (op == OP_OVL_HI) ? ~src_v[k] : src_v[k];
    assign mb  = (op == OP_OVL_HI) ? ~bl_v[k]  : bl_v[k];
    assign m16 = ma * mb;

    always_comb begin
      word_nxt.ch[k].op = op;
      word_nxt.ch[k].s  = src_v[k];
      word_nxt.ch[k].b  = bl_v[k];
      if (op == OP_OVL_LO || op == OP_OVL_HI) begin
        word_nxt.ch[k].prod = {m16[14:0], 1'b0};
      end else begin
        word_nxt.ch[k].prod = m16;
      end
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

FILE: sv/pbm_op.sv
// pbm_op: second pipeline stage; divides the product by 255 and selects
// the per-channel blend value. Depends on pbm_pkg.
module pbm_op
  import pbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_i,
  output logic       ready_o,
  input  prod_word_t word_i,
  output logic       valid_o,
  input  logic       ready_i,
  output val_word_t  word_o
);

  logic      valid_r;
  val_word_t word_r;
  val_word_t word_nxt;

  assign word_nxt.alpha = word_i.alpha;

  for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
    logic [7:0] q;
    logic [8:0] scr;

    assign q   = div255(word_i.ch[k].prod);
    assign scr = {1'b0, word_i.ch[k].s} + {1'b0, word_i.ch[k].b} - {1'b0, q};

    always_comb begin
      word_nxt.ch[k].s = word_i.ch[k].s;
      case (word_i.ch[k].op)
        OP_SCREEN: word_nxt.ch[k].v = scr[7:0];
        OP_MUL:    word_nxt.ch[k].v = q;
        OP_OVL_LO: word_nxt.ch[k].v = q;
        OP_OVL_HI: word_nxt.ch[k].v = ~q;
        OP_BLEND:  word_nxt.ch[k].v = word_i.ch[k].b;
        default:   word_nxt.ch[k].v = word_i.ch[k].s;
      endcase
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

FILE: sv/pbm_mix.sv
// pbm_mix: third and fourth pipeline stages; weighted sum of source and
// blend value by alpha, then divide by 255 into the output register.
// Depends on pbm_pkg.
module pbm_mix
  import pbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_i,
  output logic       ready_o,
  input  val_word_t  word_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] c0_o,
  output logic [7:0] c1_o,
  output logic [7:0] c2_o
);

  logic        sum_valid_r;
  logic        sum_ready;
  logic [15:0] sum_r [NUM_CH];
  logic [15:0] sum_nxt [NUM_CH];
  logic        out_valid_r;
  logic [7:0]  out_r [NUM_CH];
  logic [7:0]  out_nxt [NUM_CH];

  for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
    logic [7:0]  inv_a;
    logic [15:0] ps;
    logic [15:0] pv;

    assign inv_a      = ~word_i.alpha;
    assign ps         = word_i.ch[k].s * inv_a;
    assign pv         = word_i.ch[k].v * word_i.alpha;
    assign sum_nxt[k] = ps + pv;
    assign out_nxt[k] = div255(sum_r[k]);
  end

  assign sum_ready = !out_valid_r || ready_i;
  assign ready_o   = !sum_valid_r || sum_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready_o) begin
        sum_valid_r <= valid_i;
      end
      if (sum_ready) begin
        out_valid_r <= sum_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      sum_r <= sum_nxt;
    end
    if (sum_ready && sum_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign valid_o = out_valid_r;
  assign c0_o    = out_r[0];
  assign c1_o    = out_r[1];
  assign c2_o    = out_r[2];

endmodule

FILE: sv/pixel_blend_mode_unit.sv
// pixel_blend_mode_unit: top level; configuration registers and the
// four-stage blend pipeline. Depends on pbm_pkg, pbm_prod, pbm_op, pbm_mix.
//
//   channel   handshake             payload
//   in_       in_valid / in_stall   src_c0..2, blend_c0..2, blend_alpha
//   out_      out_valid / out_stall out_c0..2
//   cfg_      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word per cycle in unless out_stall holds the pipeline back.
// Stages: product, divide and select, weighted sum, divide into output.
// Each stage has its own valid bit and fills a bubble even while out_stall
// holds the output word. Reset clears all valid bits and loads the
// register defaults; cfg_ready is always high.
module pixel_blend_mode_unit
  import pbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_src_c0,
  input  logic [7:0] in_src_c1,
  input  logic [7:0] in_src_c2,
  input  logic [7:0] in_blend_c0,
  input  logic [7:0] in_blend_c1,
  input  logic [7:0] in_blend_c2,
  input  logic [7:0] in_blend_alpha,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_c0,
  output logic [7:0] out_c1,
  output logic [7:0] out_c2,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t       cfg_r;
  logic       prod_ready;
  logic       prod_valid;
  prod_word_t prod_word;
  logic       op_ready;
  logic       op_valid;
  val_word_t  op_word;
  logic       mix_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_PASS;
      cfg_r.format      <= FMT_RGB;
      cfg_r.const_alpha <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLEND_MODE:   cfg_r.mode        <= cfg_data[2:0];
        CFG_BLEND_FORMAT: cfg_r.format      <= cfg_data[1:0];
        CFG_CONST_ALPHA:  cfg_r.const_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  pbm_prod u_prod (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .valid_i     (in_valid),
    .ready_o     (prod_ready),
    .src_c0      (in_src_c0),
    .src_c1      (in_src_c1),
    .src_c2      (in_src_c2),
    .blend_c0    (in_blend_c0),
    .blend_c1    (in_blend_c1),
    .blend_c2    (in_blend_c2),
    .blend_alpha (in_blend_alpha),
    .valid_o     (prod_valid),
    .ready_i     (op_ready),
    .word_o      (prod_word)
  );

  pbm_op u_op (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (prod_valid),
    .ready_o (op_ready),
    .word_i  (prod_word),
    .valid_o (op_valid),
    .ready_i (mix_ready),
    .word_o  (op_word)
  );

  pbm_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (op_valid),
    .ready_o (mix_ready),
    .word_i  (op_word),
    .valid_o (out_valid),
    .ready_i (!out_stall),
    .c0_o    (out_c0),
    .c1_o    (out_c1),
    .c2_o    (out_c2)
  );

  assign in_stall = !prod_ready;

endmodule
